FILE: src/sfr_pkg.sv
package sfr_pkg;

  // bytes held in one packed pattern or replacement word
  localparam int PACKED_BYTES = 8;

  // defaults for the top level parameters
  localparam int MAX_PATTERN_LEN_DEFAULT     = 8;
  localparam int MAX_REPLACEMENT_LEN_DEFAULT = 8;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // one classified input item: bytes to emit, how many, and end of text
  typedef struct packed {
    logic [8*PACKED_BYTES-1:0] data;
    logic [3:0]                count;
    logic                      eot;
  } sfr_job_t;

endpackage

FILE: src/sfr_front.sv
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PATTERN_LEN     = MAX_PATTERN_LEN_DEFAULT,
  parameter int MAX_REPLACEMENT_LEN = MAX_REPLACEMENT_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output logic       job_push,
  output sfr_job_t   job
);

  localparam int WIN  = (MAX_PATTERN_LEN < PACKED_BYTES) ? MAX_PATTERN_LEN : PACKED_BYTES;
  localparam int RWIN = (MAX_REPLACEMENT_LEN < PACKED_BYTES) ?
                        MAX_REPLACEMENT_LEN : PACKED_BYTES;

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;

  logic [7:0] win [WIN];
  logic [3:0] fill;

  logic [3:0] plen, rlen, fill_c, fill_inc, fill_next;
  logic [7:0] w_new [WIN];
  logic       is_full, match;
  logic [63:0] w_packed;

  // effective lengths after clamping
  always_comb begin
    plen = (pattern_length == 4'd0) ? 4'd1 : pattern_length;
    if (plen > 4'(WIN)) plen = 4'(WIN);
    rlen = replacement_length;
    if (rlen > 4'(RWIN)) rlen = 4'(RWIN);
  end

  // window with the new byte placed, and the compare against the pattern
  always_comb begin
    fill_c   = (fill >= plen) ? plen - 4'd1 : fill;
    fill_inc = fill_c + 4'd1;
    is_full  = (fill_inc == plen);
    match    = 1'b1;
    w_packed = '0;
    for (int i = 0; i < WIN; i++) begin
      w_new[i] = (4'(i) == fill_c) ? text_byte : win[i];
      w_packed[8*i +: 8] = w_new[i];
      if (4'(i) < plen && w_new[i] != pattern_bytes[8*i +: 8]) match = 1'b0;
    end
  end

  // classify the item into a job for the back end
  always_comb begin
    job.eot = end_of_text;
    if (is_full && match) begin
      job.data  = replacement_bytes;
      job.count = rlen;
      fill_next = 4'd0;
    end else if (is_full) begin
      job.data  = w_packed;
      job.count = end_of_text ? plen : 4'd1;
      fill_next = plen - 4'd1;
    end else begin
      job.data  = w_packed;
      job.count = end_of_text ? fill_inc : 4'd0;
      fill_next = fill_inc;
    end
    if (end_of_text) fill_next = 4'd0;
    job_push = accept && (job.count != 4'd0 || end_of_text);
  end

  // configuration registers and window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= 4'd0;
      fill               <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES: pattern_bytes <= cfg_data;
        REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[3:0];
          fill           <= 4'd0;
        end
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
      endcase
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // window bytes, shifted by one on a mismatch
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN; i++) begin
        if (is_full && !match && i < WIN - 1) win[i] <= w_new[(i + 1) % WIN];
        else win[i] <= w_new[i];
      end
    end
  end

endmodule

FILE: src/sfr_queue.sv
module sfr_queue import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sfr_job_t wdata,
  input  logic     pop,
  output sfr_job_t rdata,
  output logic     full,
  output logic     empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sfr_job_t        entries [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wdata;
  end

endmodule

FILE: src/sfr_back.sv
module sfr_back import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sfr_job_t   job,
  input  logic       job_avail,
  output logic       job_done,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_text
);

  logic       o_valid;
  logic [2:0] idx;
  logic       load, final_one;

  assign empty     = !o_valid;
  assign load      = job_avail && (!o_valid || pop);
  assign final_one = (job.count == 4'd0) || ({1'b0, idx} == job.count - 4'd1);
  assign job_done  = load && final_one;

  // position within the current job and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (load) o_valid <= 1'b1;
      else if (pop) o_valid <= 1'b0;
      if (load) idx <= final_one ? 3'd0 : idx + 3'd1;
    end
  end

  // output register: one byte of the job, or the empty end marker
  always_ff @(posedge clk) begin
    if (load) begin
      if (job.count == 4'd0) begin
        out_byte   <= 8'd0;
        byte_valid <= 1'b0;
      end else begin
        out_byte   <= job.data[8*idx +: 8];
        byte_valid <= 1'b1;
      end
      last_of_text <= job.eot && final_one;
    end
  end

endmodule

FILE: src/stream_find_replace_top.sv
// streaming find and replace, one text byte per input item
// input channel: push with text_byte and end_of_text, taken when full is low
// result channel: out_byte, byte_valid, last_of_text shown while empty is low,
//   taken when pop is high
// config channel: cfg_valid/cfg_ready with cfg_index 0..3 and 64-bit cfg_data;
//   cfg_ready is always high, write only while no text is in flight
// the front classifies each byte against the pattern window and queues a job
//   of zero to eight result bytes; the back drains jobs one result per cycle while pop keeps the output free
// the first result of an item reaches the result ports through the job queue
//   entry and then the output register
// input takes one item per cycle while each item yields at most one result and
//   the receiver keeps popping; an item yielding several results holds the back end
//   until all are loaded, and input stalls once the four-entry job queue fills
// an end-of-text item with nothing to emit yields one marker result with
//   byte_valid low and last_of_text high
// reset empties the window fill, the job queue and the output valid flag, and
//   loads a pattern of one zero byte (length 1) and an empty replacement
// a stalled receiver holds the output register; input keeps flowing until
//   the queue is full
module stream_find_replace_top import sfr_pkg::*; #(
  parameter int MAX_PATTERN_LEN     = MAX_PATTERN_LEN_DEFAULT,
  parameter int MAX_REPLACEMENT_LEN = MAX_REPLACEMENT_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_text,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic     accept, job_push, job_done, q_empty;
  sfr_job_t job_in, job_head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // front: window, compare and classification
  sfr_front #(
    .MAX_PATTERN_LEN     (MAX_PATTERN_LEN),
    .MAX_REPLACEMENT_LEN (MAX_REPLACEMENT_LEN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .job_push    (job_push),
    .job         (job_in)
  );

  // job queue between front and back
  sfr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_done),
    .rdata (job_head),
    .full  (full),
    .empty (q_empty)
  );

  // back: expand jobs into result items
  sfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job_head),
    .job_avail    (!q_empty),
    .job_done     (job_done),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last_of_text (last_of_text)
  );

endmodule
